// ===== rtl/core/scd_pkg.sv =====
package scd_pkg;

  // field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 15;
  localparam int DELAY_W    = 12;
  localparam int DIST_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // datapath widths
  localparam int GAIN_SHIFT  = 12;
  localparam int SCALE_P_W   = SAMPLE_W + GAIN_W + 1;
  localparam int RING_W      = 20;
  localparam int Y_W         = RING_W + 1;
  localparam int MAG_W       = 20;
  localparam int DISTP_W     = DIST_W + 1;
  localparam int NUM_A_W     = MAG_W + DISTP_W;
  localparam int FRAC_SHIFT  = 15;
  localparam int NUM_W       = NUM_A_W + FRAC_SHIFT;
  localparam int DEN_W       = MAG_W + DISTP_W;
  localparam int Q_W         = 17;
  localparam int RES_MAG_W   = 16;

  localparam int RING_DEPTH_DEF = 4096;

  // constants of the distortion curve
  localparam logic [DISTP_W-1:0]   DIST_ONE  = DISTP_W'(256);
  localparam logic [DEN_W-1:0]     DEN_BIAS  = DEN_W'(8388608);
  localparam logic [RES_MAG_W-1:0] MAG_LIMIT = 16'h8000;
  localparam logic [SAMPLE_W-1:0]  POS_MAX   = 16'h7FFF;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd4096;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 12'd84;
  localparam logic [DIST_W-1:0]  DIST_RESET  = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN  = 2'd0,
    CFG_DELAY = 2'd1,
    CFG_DIST  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_WRITE,
    ST_READ,
    ST_COMB,
    ST_PROD,
    ST_DSTART,
    ST_DWAIT,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic scale;
    logic wr;
    logic rd;
    logic comb;
    logic prod;
    logic dstart;
    logic store;
    logic out_load;
    logic ch;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

// ===== rtl/core/stereo_comb_cancel_distort_unit.sv =====
// channel | ports                                         | moves
// --------+-----------------------------------------------+--------------------------------
// in      | in_valid, in_stall, in_left_in, in_right_in   | one stereo pair per request
// out     | out_valid, out_stall, out_left_out,           | one processed pair per request
//         | out_right_out                                 |
// cfg     | cfg_we, cfg_idx, cfg_wdata                    | gain, delay, distortion writes
//
// in_stall stays high from acceptance until the pair is loaded into the output register
// the serial divider gives 17 quotient bits per channel, and both channels go through it
// reset is synchronous and takes effect at once; a fill count makes unwritten ring entries
// read as zero, so no clearing pass runs
// a finished pair waits in the output register; the block takes the next request meanwhile
// but stalls requests while it works on one, and a second pair waits while the first is held
module stereo_comb_cancel_distort_unit #(
  parameter int RING_DEPTH = scd_pkg::RING_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [scd_pkg::SAMPLE_W-1:0]   in_left_in,
  input  logic signed [scd_pkg::SAMPLE_W-1:0]   in_right_in,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [scd_pkg::SAMPLE_W-1:0]   out_left_out,
  output logic signed [scd_pkg::SAMPLE_W-1:0]   out_right_out,
  // register writes
  input  logic                                  cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [scd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  // command and status between sequencer and datapath
  scd_pkg::dp_cmd_t cmd;
  scd_pkg::dp_sts_t sts;

  // sequencer: scale, ring write, ring read, comb, then per channel
  // product, divider start and wait, finally the output register load
  scd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: config registers, gain multiply, shared ring memory,
  // soft clip products and the serial divider
  scd_dp #(
    .DEPTH (RING_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

  // an accepted request makes the block busy on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block not busy afterwards");

  // a channel result is stored only when the divider has finished
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> sts.div_done)
    else $error("result stored without divider completion");

  // the output register is never overwritten while a held result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

// ===== rtl/core/scd_div.sv =====
module scd_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [scd_pkg::NUM_W-1:0]      num,
  input  logic [scd_pkg::DEN_W-1:0]      den,
  output logic                           done,
  output logic [scd_pkg::RES_MAG_W-1:0]  q_mag
);

  localparam int CNT_W = $clog2(scd_pkg::Q_W);
  localparam int NW    = scd_pkg::NUM_W;
  localparam int QW    = scd_pkg::Q_W;

  logic [NW-1:0]    rem_r, rem_nxt;
  logic [NW:0]      dsh_r, dsh_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;
  logic             ge;

  // one quotient bit per cycle, divisor shifted down
  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    ge       = {1'b0, rem_r} >= dsh_r;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {den, {(QW - 1){1'b0}}};
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(QW - 1);
      busy_nxt = 1'b1;
      ovf_nxt  = {2'b00, num} >= {den, {QW{1'b0}}};
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r[NW-1:0];
      end
      q_nxt   = {q_r[QW-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done  = done_r;
  assign q_mag = (ovf_r || (q_r > QW'(scd_pkg::MAG_LIMIT))) ? scd_pkg::MAG_LIMIT
                                                          : q_r[scd_pkg::RES_MAG_W-1:0];

endmodule

// ===== rtl/core/scd_dp.sv =====
module scd_dp #(
  parameter int DEPTH = scd_pkg::RING_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  scd_pkg::dp_cmd_t                      cmd,
  output scd_pkg::dp_sts_t                      sts,
  input  logic                                  cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [scd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic signed [scd_pkg::SAMPLE_W-1:0]   in_left_in,
  input  logic signed [scd_pkg::SAMPLE_W-1:0]   in_right_in,
  output logic signed [scd_pkg::SAMPLE_W-1:0]   out_left_out,
  output logic signed [scd_pkg::SAMPLE_W-1:0]   out_right_out
);

  localparam int AW        = $clog2(DEPTH);
  localparam int FW        = AW + 1;
  localparam int MOD_STEPS = $clog2((2 ** scd_pkg::DELAY_W + DEPTH - 1) / DEPTH);
  localparam int SW        = scd_pkg::SAMPLE_W;
  localparam int RW        = scd_pkg::RING_W;
  localparam int YW        = scd_pkg::Y_W;
  localparam int MW        = scd_pkg::MAG_W;
  localparam int PW        = scd_pkg::SCALE_P_W;
  localparam int GS        = scd_pkg::GAIN_SHIFT;

  // delay taken modulo the ring depth by restoring subtraction
  function automatic logic [AW-1:0] delay_wrap(input logic [scd_pkg::DELAY_W-1:0] dly);
    logic [scd_pkg::DELAY_W-1:0] t;
    t = dly;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (32'(t) >= (DEPTH << k)) begin
        t = t - scd_pkg::DELAY_W'(DEPTH << k);
      end
    end
    return AW'(t);
  endfunction

  // config registers
  logic [scd_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic [scd_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [AW-1:0]              dly_r, dly_nxt;

  // item registers
  logic signed [SW-1:0] x_lf_r, x_lf_nxt, x_rt_r, x_rt_nxt;
  logic [RW-1:0]        s_lf_r, s_lf_nxt, s_rt_r, s_rt_nxt;
  logic [AW-1:0]        wp_r, wp_nxt, rd_r, rd_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic                 hit_r, hit_nxt;
  logic                 sg_lf_r, sg_lf_nxt, sg_rt_r, sg_rt_nxt;
  logic [MW-1:0]        mag_lf_r, mag_lf_nxt, mag_rt_r, mag_rt_nxt;
  logic [scd_pkg::NUM_A_W-1:0] num_a_r, num_a_nxt;
  logic [scd_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [SW-1:0]        res_lf_r, res_lf_nxt, res_rt_r, res_rt_nxt;
  logic [SW-1:0]        out_lf_r, out_lf_nxt, out_rt_r, out_rt_nxt;

  // ring memory, both channels side by side
  logic [2*RW-1:0]      ring_mem [DEPTH];
  logic [2*RW-1:0]      rdata_r;

  // combinational helpers
  logic signed [PW-1:0] p_lf, p_rt;
  logic [FW-1:0]        rd_sum;
  logic [RW-1:0]        old_lf, old_rt;
  logic signed [YW-1:0] y_lf, y_rt, ny_lf, ny_rt;
  logic [MW-1:0]        mag_sel;
  logic [scd_pkg::DISTP_W-1:0] dist_p;
  logic                 sg_sel;
  logic [scd_pkg::RES_MAG_W-1:0] q_mag;
  logic [SW-1:0]        res_val;
  logic                 div_done;

  always_comb begin
    gain_nxt = gain_r;
    dist_nxt = dist_r;
    dly_nxt  = dly_r;
    if (cfg_we) begin
      case (cfg_idx)
        scd_pkg::CFG_GAIN:  gain_nxt = cfg_wdata[scd_pkg::GAIN_W-1:0];
        scd_pkg::CFG_DELAY: dly_nxt  = delay_wrap(cfg_wdata[scd_pkg::DELAY_W-1:0]);
        scd_pkg::CFG_DIST:  dist_nxt = cfg_wdata[scd_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    x_lf_nxt   = cmd.load_in ? in_left_in : x_lf_r;
    x_rt_nxt   = cmd.load_in ? in_right_in : x_rt_r;

    // scale, floor by arithmetic shift
    p_lf = $signed(PW'(x_lf_r)) * $signed({{(PW - scd_pkg::GAIN_W){1'b0}}, gain_r});
    p_rt = $signed(PW'(x_rt_r)) * $signed({{(PW - scd_pkg::GAIN_W){1'b0}}, gain_r});
    rd_sum = {1'b0, wp_r} + (FW'(DEPTH) - {1'b0, dly_r});
    s_lf_nxt = cmd.scale ? p_lf[GS+RW-1:GS] : s_lf_r;
    s_rt_nxt = cmd.scale ? p_rt[GS+RW-1:GS] : s_rt_r;
    rd_nxt   = rd_r;
    if (cmd.scale) begin
      rd_nxt = (rd_sum >= FW'(DEPTH)) ? AW'(rd_sum - FW'(DEPTH)) : rd_sum[AW-1:0];
    end

    // write position and fill level
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (cmd.wr) begin
      wp_nxt   = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      fill_nxt = (fill_r == FW'(DEPTH)) ? fill_r : fill_r + 1'b1;
    end
    hit_nxt = cmd.rd ? ({1'b0, rd_r} < fill_r) : hit_r;

    // comb difference, sign and magnitude
    old_lf = hit_r ? rdata_r[2*RW-1:RW] : '0;
    old_rt = hit_r ? rdata_r[RW-1:0] : '0;
    y_lf   = $signed({s_lf_r[RW-1], s_lf_r}) - $signed({old_lf[RW-1], old_lf});
    y_rt   = $signed({s_rt_r[RW-1], s_rt_r}) - $signed({old_rt[RW-1], old_rt});
    ny_lf  = -y_lf;
    ny_rt  = -y_rt;
    sg_lf_nxt  = cmd.comb ? y_lf[YW-1] : sg_lf_r;
    sg_rt_nxt  = cmd.comb ? y_rt[YW-1] : sg_rt_r;
    mag_lf_nxt = mag_lf_r;
    mag_rt_nxt = mag_rt_r;
    if (cmd.comb) begin
      mag_lf_nxt = y_lf[YW-1] ? ny_lf[MW-1:0] : y_lf[MW-1:0];
      mag_rt_nxt = y_rt[YW-1] ? ny_rt[MW-1:0] : y_rt[MW-1:0];
    end

    // numerator and denominator of the soft clip
    mag_sel   = cmd.ch ? mag_rt_r : mag_lf_r;
    dist_p    = {1'b0, dist_r} + scd_pkg::DIST_ONE;
    num_a_nxt = num_a_r;
    den_nxt   = den_r;
    if (cmd.prod) begin
      num_a_nxt = scd_pkg::NUM_A_W'(mag_sel) * scd_pkg::NUM_A_W'(dist_p);
      den_nxt   = scd_pkg::DEN_W'(mag_sel) * scd_pkg::DEN_W'(dist_r) + scd_pkg::DEN_BIAS;
    end

    // apply sign and saturate
    sg_sel  = cmd.ch ? sg_rt_r : sg_lf_r;
    res_val = sg_sel ? (SW'(0) - q_mag)
                     : ((q_mag == scd_pkg::MAG_LIMIT) ? scd_pkg::POS_MAX : q_mag);
    res_lf_nxt = (cmd.store && !cmd.ch) ? res_val : res_lf_r;
    res_rt_nxt = (cmd.store && cmd.ch) ? res_val : res_rt_r;

    out_lf_nxt = cmd.out_load ? res_lf_r : out_lf_r;
    out_rt_nxt = cmd.out_load ? res_rt_r : out_rt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= scd_pkg::GAIN_RESET;
      dist_r <= scd_pkg::DIST_RESET;
      dly_r  <= delay_wrap(scd_pkg::DELAY_RESET);
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      gain_r <= gain_nxt;
      dist_r <= dist_nxt;
      dly_r  <= dly_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_lf_r   <= x_lf_nxt;
    x_rt_r   <= x_rt_nxt;
    s_lf_r   <= s_lf_nxt;
    s_rt_r   <= s_rt_nxt;
    rd_r     <= rd_nxt;
    hit_r    <= hit_nxt;
    sg_lf_r  <= sg_lf_nxt;
    sg_rt_r  <= sg_rt_nxt;
    mag_lf_r <= mag_lf_nxt;
    mag_rt_r <= mag_rt_nxt;
    num_a_r  <= num_a_nxt;
    den_r    <= den_nxt;
    res_lf_r <= res_lf_nxt;
    res_rt_r <= res_rt_nxt;
    out_lf_r <= out_lf_nxt;
    out_rt_r <= out_rt_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ring_mem[wp_r] <= {s_lf_r, s_rt_r};
    end
    if (cmd.rd) begin
      rdata_r <= ring_mem[rd_r];
    end
  end

  scd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.dstart),
    .num   ({num_a_r, {scd_pkg::FRAC_SHIFT{1'b0}}}),
    .den   (den_r),
    .done  (div_done),
    .q_mag (q_mag)
  );

  assign sts.div_done  = div_done;
  assign out_left_out  = out_lf_r;
  assign out_right_out = out_rt_r;

endmodule

// ===== rtl/core/scd_ctrl.sv =====
module scd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  scd_pkg::dp_sts_t  sts,
  output scd_pkg::dp_cmd_t  cmd
);

  scd_pkg::ctrl_state_t state_r, state_nxt;
  logic                 ch_r, ch_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      scd_pkg::ST_IDLE:   if (in_valid) state_nxt = scd_pkg::ST_SCALE;
      scd_pkg::ST_SCALE:  state_nxt = scd_pkg::ST_WRITE;
      scd_pkg::ST_WRITE:  state_nxt = scd_pkg::ST_READ;
      scd_pkg::ST_READ:   state_nxt = scd_pkg::ST_COMB;
      scd_pkg::ST_COMB: begin
        state_nxt = scd_pkg::ST_PROD;
        ch_nxt    = 1'b0;
      end
      scd_pkg::ST_PROD:   state_nxt = scd_pkg::ST_DSTART;
      scd_pkg::ST_DSTART: state_nxt = scd_pkg::ST_DWAIT;
      scd_pkg::ST_DWAIT: begin
        if (sts.div_done) begin
          state_nxt = ch_r ? scd_pkg::ST_FINISH : scd_pkg::ST_PROD;
          ch_nxt    = 1'b1;
        end
      end
      scd_pkg::ST_FINISH: if (out_free) state_nxt = scd_pkg::ST_IDLE;
      default:            state_nxt = scd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.ch   = ch_r;
    in_stall = 1'b1;
    case (state_r)
      scd_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      scd_pkg::ST_SCALE:  cmd.scale    = 1'b1;
      scd_pkg::ST_WRITE:  cmd.wr       = 1'b1;
      scd_pkg::ST_READ:   cmd.rd       = 1'b1;
      scd_pkg::ST_COMB:   cmd.comb     = 1'b1;
      scd_pkg::ST_PROD:   cmd.prod     = 1'b1;
      scd_pkg::ST_DSTART: cmd.dstart   = 1'b1;
      scd_pkg::ST_DWAIT:  cmd.store    = sts.div_done;
      scd_pkg::ST_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scd_pkg::ST_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== tb/scd_notch_checker.sv =====
module scd_notch_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] in_left_in,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] in_right_in,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] out_left_out,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] out_right_out,
  input  logic                                cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [scd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                  fail_count,
  output int                                  pairs_in_flight,
  output int                                  pairs_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import scd_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int LEFT_CH     = 0;
  localparam int RIGHT_CH    = 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_pair_t;

  // shadow registers and delay rings
  logic [GAIN_W-1:0]        gain_r;
  logic [DELAY_W-1:0]       delay_r;
  logic [DIST_W-1:0]        dist_r;
  logic signed [RING_W-1:0] ring [2][RING_DEPTH_DEF];
  logic [DELAY_W-1:0]       write_pos;
  logic [DELAY_W-1:0]       read_pos;

  stereo_pair_t notched_pairs [$];
  stereo_pair_t due;
  int           fails;
  int           checked;

  // scale, write the ring, subtract the delayed entry, soft clip, saturate
  function automatic logic signed [SAMPLE_W-1:0] comb_distort(
    input int                         ch,
    input logic signed [SAMPLE_W-1:0] x,
    input logic [DELAY_W-1:0]         rd
  );
    longint scaled;
    longint diff;
    longint mag;
    longint quo;
    longint res;
    scaled = (longint'(x) * longint'(gain_r)) >>> GAIN_SHIFT;
    ring[ch][write_pos] = scaled[RING_W-1:0];
    diff = scaled - longint'(ring[ch][rd]);
    mag = (diff < 0) ? -diff : diff;
    quo = (mag * (longint'(dist_r) + 256) * 32768) / (longint'(dist_r) * mag + 8388608);
    if (quo > 32768) quo = 32768;
    res = (diff < 0) ? -quo : quo;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_r    = GAIN_RESET;
      delay_r   = DELAY_RESET;
      dist_r    = DIST_RESET;
      write_pos = '0;
      for (int i = 0; i < RING_DEPTH_DEF; i++) begin
        ring[LEFT_CH][i]  = '0;
        ring[RIGHT_CH][i] = '0;
      end
      notched_pairs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAIN:  gain_r  = cfg_wdata[GAIN_W-1:0];
          CFG_DELAY: delay_r = cfg_wdata[DELAY_W-1:0];
          CFG_DIST:  dist_r  = cfg_wdata[DIST_W-1:0];
          default: ;
        endcase
      end

      // compare before predicting so a result never meets its own request
      if (out_valid && !out_stall) begin
        if (notched_pairs.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result with nothing due, left %0d right %0d",
                     $realtime, out_left_out, out_right_out);
        end else begin
          due = notched_pairs.pop_front();
          checked++;
          if (out_left_out !== due.left || out_right_out !== due.right) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d",
                       $realtime, due.left, out_left_out, due.right, out_right_out);
          end
        end
      end

      if (in_valid && !in_stall) begin
        read_pos  = write_pos - delay_r;
        due.left  = comb_distort(LEFT_CH, in_left_in, read_pos);
        due.right = comb_distort(RIGHT_CH, in_right_in, read_pos);
        notched_pairs.push_back(due);
        write_pos = write_pos + 1'b1;
      end
    end
    fail_count      <= fails;
    pairs_in_flight <= notched_pairs.size();
    pairs_checked   <= checked;
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scd_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  // settle time after the last result, with headroom
  localparam int SETTLE_CYCLES   = 64;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int RANDOM_PHASES   = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // pressure mixes
  localparam int MIX_NONE   = 0;
  localparam int MIX_SENDER = 1;
  localparam int MIX_RECV   = 2;
  localparam int MIX_BOTH   = 3;

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_left_in    = '0;
  logic signed [SAMPLE_W-1:0] in_right_in   = '0;
  logic                       out_valid;
  logic                       out_stall     = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left_out;
  logic signed [SAMPLE_W-1:0] out_right_out;
  logic                       cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx       = CFG_GAIN;
  logic [CFG_DATA_W-1:0]      cfg_wdata     = '0;

  int fail_count;
  int pairs_in_flight;
  int pairs_checked;

  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int pairs_sent  = 0;
  int settings_used = 0;

  // history of sent pairs, indexed like the block's write position
  logic signed [SAMPLE_W-1:0] sent_left  [RING_DEPTH_DEF];
  logic signed [SAMPLE_W-1:0] sent_right [RING_DEPTH_DEF];
  logic [DELAY_W-1:0]         cur_delay = DELAY_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stereo_comb_cancel_distort_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata)
  );

  scd_notch_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pairs_in_flight (pairs_in_flight),
    .pairs_checked   (pairs_checked)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pairs_in_flight);
      $display("stereo_comb_cancel_distort_unit test failed");
      $finish;
    end
  end

  task automatic set_mix(input int mix);
    case (mix)
      MIX_NONE: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      MIX_SENDER: begin
        idle_pct = 46;
        stall_pct <= 0;
      end
      MIX_RECV: begin
        idle_pct = 0;
        stall_pct <= 46;
      end
      default: begin
        idle_pct = 30;
        stall_pct <= 30;
      end
    endcase
  endtask

  // one write per cycle; spare upper data bits are set at random and
  // the unused index gets junk, neither may change anything
  task automatic program_regs(input logic [GAIN_W-1:0] g, input logic [DELAY_W-1:0] dl,
                              input logic [DIST_W-1:0] ds);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GAIN;
    cfg_wdata <= {1'($urandom_range(1)), g};
    @(posedge clk);
    cfg_idx   <= CFG_DELAY;
    cfg_wdata <= {4'($urandom_range(15)), dl};
    @(posedge clk);
    cfg_idx   <= CFG_DIST;
    cfg_wdata <= ds;
    @(posedge clk);
    cfg_idx   <= CFG_UNUSED;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    cur_delay = dl;
    settings_used++;
  endtask

  // optional idle gap, then hold the request until the block takes it
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_left_in  <= l;
    in_right_in <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_left[pairs_sent % RING_DEPTH_DEF]  = l;
    sent_right[pairs_sent % RING_DEPTH_DEF] = r;
    pairs_sent++;
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pairs_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] edge_sample();
    case ($urandom_range(5))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_MIN + 16'sd1;
      3:       return '0;
      4:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mixed_sample();
    case ($urandom_range(5))
      0:       return edge_sample();
      1:       return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // in four of ten pairs a signal periodic in the comb delay so the notch
  // really cancels, otherwise wide or small noise and edge values
  task automatic send_random_pair();
    logic [DELAY_W-1:0] back;
    back = DELAY_W'(pairs_sent) - cur_delay;
    if ($urandom_range(9) < 4)
      send_pair(sent_left[back], sent_right[back]);
    else
      send_pair(mixed_sample(), mixed_sample());
  endtask

  initial begin
    logic [GAIN_W-1:0]  g;
    logic [DELAY_W-1:0] dl;
    logic [DIST_W-1:0]  ds;

    for (int i = 0; i < RING_DEPTH_DEF; i++) begin
      sent_left[i]  = '0;
      sent_right[i] = '0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, rings still empty so the delayed read is zero
    set_mix(MIX_BOTH);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sd1, -16'sd1);
    drain();

    // max gain, one-sample delay, max distortion: big swings and clipping
    program_regs(15'd32767, 12'd1, 16'hFFFF);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd16384, -16'sd16384);
    drain();

    // zero gain with zero delay
    program_regs(15'd0, 12'd0, 16'd256);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(16'sd12345, -16'sd12345);
    drain();

    // unity gain with zero delay: the fresh entry cancels itself
    program_regs(15'd4096, 12'd0, 16'd0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(-16'sd1, 16'sd1);
    drain();

    // longest delay reaches entries never written
    program_regs(15'd4096, 12'd4095, 16'd0);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(16'sd777, -16'sd778);
    send_pair(SAMPLE_MAX, -16'sd1);
    drain();

    program_regs(15'd20000, 12'd2, 16'd300);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(16'sd0, 16'sd0);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    drain();

    // random phases, each with its own settings and pressure mix
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          g = GAIN_RESET;
          dl = DELAY_RESET;
          ds = DIST_RESET;
        end
        1: begin
          g = 15'($urandom);
          dl = 12'($urandom_range(100, 1));
          ds = 16'($urandom_range(1023));
        end
        2: begin
          g = 15'd32767;
          dl = 12'd4095;
          ds = 16'hFFFF;
        end
        3: begin
          g = 15'($urandom_range(8191));
          dl = 12'd1;
          ds = 16'd0;
        end
        5: begin
          g = 15'd2048;
          dl = 12'd0;
          ds = 16'($urandom);
        end
        7: begin
          g = 15'($urandom);
          dl = 12'd1;
          ds = 16'hFFFF;
        end
        default: begin
          g = 15'($urandom);
          dl = 12'($urandom);
          ds = 16'($urandom);
        end
      endcase
      set_mix(ph % 4);
      program_regs(g, dl, ds);
      repeat (ITEMS_PER_PHASE) send_random_pair();
      drain();
    end

    $display("%0d stereo pairs over %0d register settings: gain, delay and distortion extremes,",
             pairs_sent, settings_used);
    $display("zero delay, unused index writes; %0d results compared under four pressure mixes",
             pairs_checked);
    if (fail_count == 0 && pairs_in_flight == 0) begin
      $display("stereo_comb_cancel_distort_unit test passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pairs_in_flight);
      $display("stereo_comb_cancel_distort_unit test failed");
    end
    $finish;
  end

endmodule
